/* hw/rtl/srm_pkg.sv */
// Package for the symmetry reflection merge unit: constants, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srm_pkg;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_SYM_DEF     = 48;
    localparam int IDX_W           = 7;
    localparam int INT_W           = 32;
    localparam int MULT_W          = 16;
    localparam int SLOT_W          = 8;
    localparam int MAT_W           = 18;
    localparam int NOPS_W          = 6;
    localparam int IN_DATA_W       = 80;  // 7*3+32+8+18 = 79 -> 80
    localparam int OUT_DATA_W      = 80;  // 8+1+1+16+7*3+32+1 = 80

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_SUBMIT = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    localparam logic [1:0] REG_NUM_SYM_OPS = 2'd0;

    // One decoded item handed from the front to the back through the queue.
    typedef struct packed {
        func_t               func;
        logic signed [IDX_W-1:0] h;
        logic signed [IDX_W-1:0] k;
        logic signed [IDX_W-1:0] l;
        logic [INT_W-1:0]    inten;
        logic [SLOT_W-1:0]   slot;
        logic [MAT_W-1:0]    mat;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]       entry_index;
        logic                    is_new;
        logic                    table_full;
        logic [MULT_W-1:0]       mult;
        logic signed [IDX_W-1:0] h;
        logic signed [IDX_W-1:0] k;
        logic signed [IDX_W-1:0] l;
        logic [INT_W-1:0]        inten;
        logic                    valid;
    } result_t;

    // Element at row r, column c of a packed matrix, as a signed 2-bit value.
    function automatic logic signed [1:0] mat_elem(input logic [MAT_W-1:0] m,
                                                   input int r, input int c);
        return m[6*r+2*c +: 2];
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/srm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module srm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/srm_front.sv */
// Front end: accepts stream words, unpacks and classifies them, queues them for the back end.
// Depends on srm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srm_front #(
    parameter int QDEPTH = 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [79:0]   s_tdata,
    input  wire logic [1:0]    s_tuser,
    output logic               q_valid,
    input  wire logic          q_pop,
    output srm_pkg::item_t     q_item
);
    import srm_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    item_t           q_reg [QDEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [PW:0]     cnt_reg;
    item_t           in_item;
    logic            push;

    always_comb begin
        in_item.func  = func_t'(s_tuser);
        in_item.h     = s_tdata[6:0];
        in_item.k     = s_tdata[13:7];
        in_item.l     = s_tdata[20:14];
        in_item.inten = s_tdata[52:21];
        in_item.slot  = s_tdata[60:53];
        in_item.mat   = s_tdata[78:61];
    end

    assign s_tready = (cnt_reg != (PW+1)'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg] <= in_item;
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(QDEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_reg <= (rd_reg == PW'(QDEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(q_pop);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/srm_back.sv */
// Back end: sequencer that loads ops, scans the entry table per op, updates and reads entries.
// Depends on srm_pkg and srm_ram.
`timescale 1ns / 1ps
`default_nettype none
module srm_back #(
    parameter int TABLE_DEPTH = srm_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_SYM     = srm_pkg::MAX_SYM_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [5:0]           num_sym_ops,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire srm_pkg::item_t       q_item,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output srm_pkg::result_t          res
);
    import srm_pkg::*;

    localparam int EAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SAW = (MAX_SYM > 1) ? $clog2(MAX_SYM) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int OW  = $clog2(MAX_SYM + 1) > NOPS_W ? $clog2(MAX_SYM + 1) : NOPS_W;
    // entry record: h,k,l,sum(9),intensity,mult
    localparam int EW  = 3*IDX_W + 9 + INT_W + MULT_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_OPRD  = 8'b0000_0010,
        S_XFORM = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_CMP   = 8'b0001_0000,
        S_UPD   = 8'b0010_0000,
        S_RDW   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    item_t                   it_reg;
    logic [CW-1:0]           count_reg;
    logic [OW-1:0]           op_reg, nops;
    logic [CW-1:0]           e_reg;
    logic signed [8:0]       t_h_reg, t_k_reg, t_l_reg;
    result_t                 res_reg, res_next;
    logic                    res_valid_reg;
    logic                    hit_reg;
    logic                    full_drop;

    // op RAM
    logic                    load_we;
    logic [SAW-1:0]          op_raddr;
    logic [MAT_W-1:0]        op_rdata;
    // entry RAM
    logic                    en_we;
    logic [EAW-1:0]          en_waddr, en_raddr;
    logic [EW-1:0]           en_wdata, en_rdata;

    // op RAM written from the back end when the load word retires
    srm_ram #(.WIDTH(MAT_W), .DEPTH(MAX_SYM)) u_ops (
        .aclk(aclk), .we(load_we), .waddr(it_reg.slot[SAW-1:0]), .wdata(it_reg.mat),
        .raddr(op_raddr), .rdata(op_rdata)
    );
    srm_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ent (
        .aclk(aclk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
        .raddr(en_raddr), .rdata(en_rdata)
    );

    logic signed [IDX_W-1:0] eh, ek, el;
    logic signed [8:0]       esum, nsum;
    logic [INT_W-1:0]        eint;
    logic [MULT_W-1:0]       emult;
    logic                    match;
    logic signed [8:0]       xf [3];

    assign {eh, ek, el, esum, eint, emult} = en_rdata;
    assign nsum = 9'(it_reg.h) + 9'(it_reg.k) + 9'(it_reg.l);
    assign match = (t_h_reg == 9'(eh)) && (t_k_reg == 9'(ek)) && (t_l_reg == 9'(el))
                && (eint == it_reg.inten);
    assign nops = (OW'(num_sym_ops) > OW'(MAX_SYM)) ? OW'(MAX_SYM) : OW'(num_sym_ops);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            xf[c] = 9'(mat_elem(op_rdata, 0, c)) * 9'(it_reg.h)
                  + 9'(mat_elem(op_rdata, 1, c)) * 9'(it_reg.k)
                  + 9'(mat_elem(op_rdata, 2, c)) * 9'(it_reg.l);
        end
    end

    assign op_raddr  = op_reg[SAW-1:0];
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && !res_valid_reg;
    assign load_we   = (state_reg == S_OUT) && (it_reg.func == FUNC_LOAD)
                    && ({1'b0, it_reg.slot} < 9'(MAX_SYM));

    always_comb begin
        en_raddr = e_reg[EAW-1:0];
        if (state_reg == S_IDLE) begin
            en_raddr = '0;
        end
    end

    // entry write on update/append; a full table drops the append
    always_comb begin
        en_we    = 1'b0;
        en_waddr = e_reg[EAW-1:0];
        en_wdata = en_rdata;
        if (state_reg == S_UPD) begin
            if (hit_reg) begin
                en_we    = 1'b1;
                en_wdata = (nsum > esum) ?
                    {it_reg.h, it_reg.k, it_reg.l, nsum, eint,
                     (emult == '1) ? emult : emult + 1'b1} :
                    {eh, ek, el, esum, eint, (emult == '1) ? emult : emult + 1'b1};
            end else begin
                en_we    = (count_reg != CW'(TABLE_DEPTH));
                en_waddr = count_reg[EAW-1:0];
                en_wdata = {it_reg.h, it_reg.k, it_reg.l, nsum, it_reg.inten,
                            MULT_W'(1)};
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_pop) state_next = S_OPRD;
            S_OPRD: begin
                priority if (it_reg.func == FUNC_SUBMIT && op_reg < nops) begin
                    state_next = S_XFORM;
                end else if (it_reg.func == FUNC_SUBMIT) begin
                    state_next = S_UPD;
                end else if (it_reg.func == FUNC_READ) begin
                    state_next = S_RDW;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_XFORM: state_next = S_SCAN;
            S_SCAN:  state_next = (e_reg < count_reg) ? S_CMP : S_OPRD;
            S_CMP:   state_next = match ? S_UPD : S_SCAN;
            S_UPD:   state_next = S_RDW;
            S_RDW:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            it_reg <= q_item;
        end
        if (state_reg == S_XFORM) begin
            t_h_reg <= xf[0];
            t_k_reg <= xf[1];
            t_l_reg <= xf[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            op_reg        <= '0;
            e_reg         <= '0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    op_reg  <= '0;
                    e_reg   <= '0;
                    hit_reg <= 1'b0;
                end
                S_OPRD: begin
                    priority if (it_reg.func == FUNC_READ) begin
                        e_reg <= CW'(it_reg.slot);
                    end else if (it_reg.func == FUNC_SUBMIT && op_reg >= nops) begin
                        e_reg <= count_reg;
                    end else begin
                        e_reg <= '0;
                    end
                end
                S_XFORM: ;
                S_SCAN: begin
                    if (e_reg >= count_reg) begin
                        op_reg <= op_reg + 1'b1;
                    end
                end
                S_CMP: begin
                    if (match) begin
                        hit_reg <= 1'b1;
                    end else begin
                        e_reg <= e_reg + 1'b1;
                    end
                end
                S_UPD: begin
                    if (!hit_reg && count_reg != CW'(TABLE_DEPTH)) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                S_RDW: ;
                S_OUT: begin
                    res_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // assemble the result while the registered read lands
    always_comb begin
        res_next = '0;
        unique case (it_reg.func)
            FUNC_SUBMIT: begin
                if (full_drop) begin
                    res_next.table_full = 1'b1;
                end else begin
                    res_next.entry_index = SLOT_W'(e_reg);
                    res_next.is_new      = !hit_reg;
                    res_next.mult        = emult;
                    res_next.h           = eh;
                    res_next.k           = ek;
                    res_next.l           = el;
                    res_next.inten       = eint;
                    res_next.valid       = 1'b1;
                end
            end
            FUNC_READ: begin
                res_next.entry_index = it_reg.slot;
                if (e_reg < count_reg) begin
                    res_next.mult  = emult;
                    res_next.h     = eh;
                    res_next.k     = ek;
                    res_next.l     = el;
                    res_next.inten = eint;
                    res_next.valid = 1'b1;
                end
            end
            FUNC_LOAD, FUNC_NONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_UPD) begin
            full_drop <= !hit_reg && (count_reg == CW'(TABLE_DEPTH));
        end
        if (state_reg == S_OUT) begin
            res_reg <= res_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/symmetry_reflection_merge_unit.sv */
// Top level of the symmetry reflection merge unit: config register, front, back, output packing.
// Depends on srm_pkg, srm_front, srm_back.
`timescale 1ns / 1ps
`default_nettype none
// Time from the accepting edge to m_tvalid: reads take longer than load and empty words by
//   the entry RAM read in S_RDW; submits are set by the entry scan (S_XFORM per op, then
//   S_SCAN and S_CMP per stored entry through the entry RAM read port); a match ends it early.
//   nops is num_sym_ops capped at MAX_SYM; a result waiting on m_tready adds its wait.
// Throughput: one word at a time in the back end; the front queue takes two more.
// Reset: synchronous active low; entry count clears to zero, num_sym_ops to 1.
module symmetry_reflection_merge_unit #(
    parameter int TABLE_DEPTH = srm_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_SYM     = srm_pkg::MAX_SYM_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // h[6:0] k[13:7] l[20:14] intensity[52:21] slot[60:53] sym_matrix[78:61]
    input  wire logic [srm_pkg::IN_DATA_W-1:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // entry_index[7:0] is_new[8] table_full[9] multiplicity[25:10] rep_h[32:26]
    // rep_k[39:33] rep_l[46:40] rep_intensity[78:47] entry_valid[79]
    output logic [srm_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import srm_pkg::*;

    logic [NOPS_W-1:0] nops_reg;
    logic              q_valid, q_pop;
    item_t             q_item;
    result_t           res;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_NUM_SYM_OPS) ? {26'd0, nops_reg} : 32'd0;

    // take the register write on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nops_reg <= NOPS_W'(1);
        end else if (psel && penable && pwrite && paddr == REG_NUM_SYM_OPS) begin
            nops_reg <= pwdata[NOPS_W-1:0];
        end
    end

    srm_front #(.QDEPTH(2)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_valid, .q_pop, .q_item
    );

    srm_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_SYM(MAX_SYM)) u_back (
        .aclk, .aresetn, .num_sym_ops(nops_reg), .q_valid, .q_pop, .q_item,
        .res_valid(m_tvalid), .res_ready(m_tready), .res
    );

    assign m_tdata = {res.valid, res.inten, res.l, res.k, res.h, res.mult,
                      res.table_full, res.is_new, res.entry_index};
endmodule
`default_nettype wire

/* hw/rtl/srm_checker.sv */
// Port-level checker for the merge unit, bound to the top level.
// Depends on symmetry_reflection_merge_unit ports only.
`timescale 1ns / 1ps
`default_nettype none
module srm_port_assertions (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic        pready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_new_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[79] && !m_tdata[9])
        else $error("new entry not valid");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> !m_tdata[79] && !m_tdata[8])
        else $error("full drop carries entry");
    a_ready: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind symmetry_reflection_merge_unit srm_port_assertions u_chk (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .pready
);
`default_nettype wire
